FILE: rtl/tcp_connection_slot_register_defines.svh
// Assertion macros for the connection-slot table checker
`ifndef TCP_CONNECTION_SLOT_REGISTER_DEFINES_SVH
`define TCP_CONNECTION_SLOT_REGISTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCSR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcsr check failed");

// next-cycle implication, sampled on clk, off during reset
`define TCSR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcsr check failed");

`endif

FILE: rtl/tcsr_pkg.sv
// Shared types, codes and constants of the connection-slot table
`default_nettype none
package tcsr_pkg;

	localparam int unsigned NUM_SLOTS_DEF = 16;
	localparam int unsigned PADDR_W       = 3;

	localparam logic [15:0] PORT_LOW  = 16'd33000;
	localparam logic [15:0] PORT_HIGH = 16'd63000;

	localparam logic [1:0] REQ_ACTIVE  = 2'd0;
	localparam logic [1:0] REQ_PASSIVE = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_DUP  = 2'd2;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_FREE    = 2'd0;
	localparam mode_t MODE_LISTEN  = 2'd1;
	localparam mode_t MODE_SYNSENT = 2'd2;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] lip;
		logic [31:0] rip;
		logic [15:0] lport;
		logic [15:0] rport;
	} entry_t;

	function automatic logic [15:0] port_next(input logic [15:0] p);
		logic [16:0] s;
		s = {1'b0, p} + 17'd1;
		if (s > {1'b0, PORT_HIGH}) begin
			return PORT_LOW;
		end
		return s[15:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tcp_connection_slot_register.sv
// Top level of the connection-slot table: request sequencer, config port, result register
//
// Each request is taken alone; in_stall stays high until its result has been
// loaded into the output register. A release or an unknown request goes from
// idle straight to the done state. An open walks every slot through the single
// read port of the slot memory and one shared tuple/listener compare unit, one
// slot per cycle, in one pass over the table; an active open makes a further
// pass for each candidate port already in use.
// The output register holds a finished result until taken while the next
// request is accepted. All slots are free after reset; no clearing pass is run.
`default_nettype none
module tcp_connection_slot_register
	import tcsr_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [31:0]        addr,
	input  wire logic [15:0]        port_num,
	input  wire logic [3:0]         release_slot,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    ok,
	output logic [3:0]              slot_index,
	output logic [15:0]             assigned_port,
	output logic [1:0]              error_code
);

	localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CAND_W = $clog2(NUM_SLOTS + 1);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [CAND_W-1:0] CAND_MAX = CAND_W'(NUM_SLOTS);
	localparam logic [8:0]        SLOT_LIM = 9'(NUM_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [31:0]         local_ip_q;
	logic [15:0]         next_port_q;
	logic [1:0]          req_q;
	logic [31:0]         addr_q;
	logic [15:0]         port_q;
	logic [3:0]          rel_q;
	logic [SLOT_W-1:0]   idx_q;
	logic                issue_q;
	logic                rd_vld_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic                free_fnd_q;
	logic [SLOT_W-1:0]   free_idx_q;
	logic                hit_q;
	logic                dup_q;
	logic [CAND_W-1:0]   cand_q;
	logic                wr_pend_q;
	logic                rel_pend_q;
	logic                res_ok_q;
	logic [3:0]          res_slot_q;
	logic [1:0]          res_err_q;
	logic                out_valid_q;
	logic                out_ok_q;
	logic [3:0]          out_slot_q;
	logic [15:0]         out_port_q;
	logic [1:0]          out_err_q;

	entry_t              rd_entry;
	entry_t              wr_entry;
	logic                wr_en;
	logic                clr_en;
	logic [SLOT_W-1:0]   clr_idx;
	logic [SLOT_W+3:0]   rel_ext;
	logic [SLOT_W+3:0]   sel_ext;
	logic                cur_free;
	logic                cur_hit;
	logic                cur_dup;
	logic                any_free;
	logic                any_hit;
	logic                any_dup;
	logic [SLOT_W-1:0]   sel_free;
	logic                last;
	logic                in_xfer;
	logic                out_free;
	logic                load_out;
	logic                cfg_wr;
	logic                rel_ok;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = paddr[2] ? 32'd0 : local_ip_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_DONE) && out_free;

	assign rel_ok   = ({5'd0, release_slot} < SLOT_LIM);

	assign cur_free = (rd_entry.mode == MODE_FREE);
	assign cur_hit  = !cur_free && (rd_entry.lip == local_ip_q) && (rd_entry.rip == addr_q) &&
		(rd_entry.lport == next_port_q) && (rd_entry.rport == port_q);
	assign cur_dup  = (rd_entry.mode == MODE_LISTEN) && (rd_entry.lip == addr_q) &&
		(rd_entry.lport == port_q);

	assign any_free = free_fnd_q || (rd_vld_s1 && cur_free);
	assign any_hit  = hit_q || (rd_vld_s1 && cur_hit);
	assign any_dup  = dup_q || (rd_vld_s1 && cur_dup);
	assign sel_free = free_fnd_q ? free_idx_q : idx_s1;
	assign last     = (state_q == ST_SCAN) && rd_vld_s1 && (idx_s1 == LAST_IDX);
	assign sel_ext  = {4'd0, sel_free};

	assign wr_en    = load_out && wr_pend_q;
	assign clr_en   = load_out && rel_pend_q;
	assign rel_ext  = {{SLOT_W{1'b0}}, rel_q};
	assign clr_idx  = rel_ext[SLOT_W-1:0];

	always_comb begin
		if (req_q == REQ_ACTIVE) begin
			wr_entry = '{mode: MODE_SYNSENT, lip: local_ip_q, rip: addr_q,
				lport: next_port_q, rport: port_q};
		end else begin
			wr_entry = '{mode: MODE_LISTEN, lip: addr_q, rip: 32'd0,
				lport: port_q, rport: 16'd0};
		end
	end

	tcsr_table #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx_q),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_idx   (free_idx_q),
		.wr_entry (wr_entry),
		.clr_en   (clr_en),
		.clr_idx  (clr_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			local_ip_q  <= 32'd0;
			next_port_q <= PORT_LOW;
			issue_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			free_fnd_q  <= 1'b0;
			hit_q       <= 1'b0;
			dup_q       <= 1'b0;
			cand_q      <= '0;
			wr_pend_q   <= 1'b0;
			rel_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && !paddr[2]) begin
				local_ip_q <= pwdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= issue_q;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						free_fnd_q <= 1'b0;
						hit_q      <= 1'b0;
						dup_q      <= 1'b0;
						cand_q     <= '0;
						if (req_type == REQ_ACTIVE || req_type == REQ_PASSIVE) begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							rel_pend_q <= (req_type == REQ_RELEASE) && rel_ok;
							state_q    <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q && idx_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end
					if (rd_vld_s1) begin
						free_fnd_q <= any_free;
						hit_q      <= any_hit;
						dup_q      <= any_dup;
					end
					if (last) begin
						priority if (!any_free) begin
							state_q <= ST_DONE;
						end else if (req_q == REQ_PASSIVE) begin
							wr_pend_q <= !any_dup;
							state_q   <= ST_DONE;
						end else if (!any_hit) begin
							wr_pend_q <= 1'b1;
							state_q   <= ST_DONE;
						end else begin
							next_port_q <= port_next(next_port_q);
							cand_q      <= cand_q + 1'b1;
							hit_q       <= 1'b0;
							dup_q       <= 1'b0;
							if (cand_q == CAND_MAX) begin
								wr_pend_q <= 1'b1;
								state_q   <= ST_DONE;
							end else begin
								issue_q <= 1'b1;
							end
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						wr_pend_q   <= 1'b0;
						rel_pend_q  <= 1'b0;
						state_q     <= ST_IDLE;
						if (wr_pend_q && req_q == REQ_ACTIVE) begin
							next_port_q <= port_next(next_port_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q      <= req_type;
			addr_q     <= addr;
			port_q     <= port_num;
			rel_q      <= release_slot;
			idx_q      <= '0;
			res_ok_q   <= (req_type == REQ_RELEASE) && rel_ok;
			res_slot_q <= (req_type == REQ_RELEASE) ? release_slot : 4'd0;
			res_err_q  <= ERR_NONE;
		end
		if (issue_q) begin
			idx_q <= idx_q + 1'b1;
		end
		if (last && any_hit && any_free && req_q == REQ_ACTIVE && cand_q != CAND_MAX) begin
			idx_q <= '0;
		end
		idx_s1 <= idx_q;
		if (rd_vld_s1) begin
			free_idx_q <= sel_free;
		end
		if (last) begin
			priority if (!any_free) begin
				res_err_q <= ERR_FULL;
			end else if (req_q == REQ_PASSIVE && any_dup) begin
				res_err_q <= ERR_DUP;
			end else if (req_q == REQ_PASSIVE || !any_hit || cand_q == CAND_MAX) begin
				res_ok_q   <= 1'b1;
				res_slot_q <= sel_ext[3:0];
			end else begin
				res_ok_q <= 1'b0;
			end
		end
		if (load_out) begin
			out_ok_q   <= res_ok_q;
			out_slot_q <= res_slot_q;
			out_err_q  <= res_err_q;
			out_port_q <= (wr_pend_q && req_q == REQ_ACTIVE) ? next_port_q : 16'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = out_ok_q;
	assign slot_index    = out_slot_q;
	assign assigned_port = out_port_q;
	assign error_code    = out_err_q;

endmodule
`default_nettype wire

FILE: rtl/tcsr_table.sv
// Slot memory with per-slot occupancy bits and one registered read port
`default_nettype none
module tcsr_table
	import tcsr_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SLOT_W-1:0] rd_idx,
	output entry_t                 rd_entry,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_idx,
	input  wire entry_t            wr_entry,
	input  wire logic              clr_en,
	input  wire logic [SLOT_W-1:0] clr_idx
);

	entry_t                 mem [NUM_SLOTS];
	entry_t                 rd_data_q;
	logic                   rd_occ_q;
	logic [NUM_SLOTS-1:0]   occ_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		rd_data_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			rd_occ_q <= 1'b0;
		end else begin
			rd_occ_q <= occ_q[rd_idx];
			if (wr_en) begin
				occ_q[wr_idx] <= 1'b1;
			end
			if (clr_en) begin
				occ_q[clr_idx] <= 1'b0;
			end
		end
	end

	assign rd_entry = rd_occ_q ? rd_data_q : '0;

endmodule
`default_nettype wire

FILE: rtl/tcsr_checker.sv
// Port-level checker for the connection-slot table and its bind
`default_nettype none
`include "tcp_connection_slot_register_defines.svh"
module tcsr_checker
	import tcsr_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               ok,
	input wire logic [3:0]         slot_index,
	input wire logic [15:0]        assigned_port,
	input wire logic [1:0]         error_code
);

	`TCSR_ASSERT_NXT(a_busy_after_xfer, in_valid && !in_stall, in_stall)
	`TCSR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ok) && $stable(slot_index) && $stable(assigned_port) && $stable(error_code))
	`TCSR_ASSERT_IMP(a_err_clean, out_valid && error_code != ERR_NONE, !ok && slot_index == 4'd0 && assigned_port == 16'd0)
	`TCSR_ASSERT_IMP(a_port_range, out_valid && assigned_port != 16'd0, ok && error_code == ERR_NONE && assigned_port >= PORT_LOW && assigned_port <= PORT_HIGH)

endmodule

bind tcp_connection_slot_register tcsr_checker u_tcsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.ok            (ok),
	.slot_index    (slot_index),
	.assigned_port (assigned_port),
	.error_code    (error_code)
);
`default_nettype wire
